>>> sv/sem_pkg.sv
// Package for the Sobel edge magnitude block: sizes, codes, payload types
// and the gradient helper. Used by every module of the block but sem_ram; depends on nothing.
package sem_pkg;

  // Image geometry limits.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_W      = 13;

  // Pixel and arithmetic widths.
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int GRAD_W = 11;
  localparam int ABS_W  = 10;
  localparam int SQ_W   = 20;
  localparam int SUM_W  = 21;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes and operation codes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    grad_t gx;
    grad_t gy;
  } grad_pair_t;

  typedef struct packed {
    grad_pair_t red;
    grad_pair_t green;
    grad_pair_t blue;
    logic       last;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Sobel Gx and Gy of one 8-bit channel; pab is row a (top first), column b.
  function automatic grad_pair_t sobel_grad(
    input logic [CH_W-1:0] p00, input logic [CH_W-1:0] p01, input logic [CH_W-1:0] p02,
    input logic [CH_W-1:0] p10, input logic [CH_W-1:0] p12,
    input logic [CH_W-1:0] p20, input logic [CH_W-1:0] p21, input logic [CH_W-1:0] p22);
    logic [ABS_W-1:0] xpos;
    logic [ABS_W-1:0] xneg;
    logic [ABS_W-1:0] ypos;
    logic [ABS_W-1:0] yneg;
    grad_pair_t       res;
    xpos = {2'b00, p02} + {1'b0, p12, 1'b0} + {2'b00, p22};
    xneg = {2'b00, p00} + {1'b0, p10, 1'b0} + {2'b00, p20};
    ypos = {2'b00, p20} + {1'b0, p21, 1'b0} + {2'b00, p22};
    yneg = {2'b00, p00} + {1'b0, p01, 1'b0} + {2'b00, p02};
    res.gx = grad_t'({1'b0, xpos}) - grad_t'({1'b0, xneg});
    res.gy = grad_t'({1'b0, ypos}) - grad_t'({1'b0, yneg});
    return res;
  endfunction

endpackage

>>> sv/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the line buffer of the Sobel block.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sem_front.sv
// Front end of the Sobel block: configuration, raster counters, line buffer,
// 3x3 window and gradient sums. Depends on sem_pkg and sem_ram.
module sem_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [7:0]              in_red_in,
  input  logic [7:0]              in_green_in,
  input  logic [7:0]              in_blue_in,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [sem_pkg::CFG_W-1:0] cfg_data,
  input  sem_pkg::q_status_t      q_status,
  output logic                    push,
  output sem_pkg::work_t          push_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic                       state_r, state_nxt;
  logic [sem_pkg::WID_W-1:0]  width_r, width_nxt;
  logic [sem_pkg::HGT_W-1:0]  height_r, height_nxt;
  logic [sem_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [sem_pkg::COL_W-1:0]  col_r, col_nxt;
  sem_pkg::pix_t              pix_r, pix_nxt;
  sem_pkg::pix_t              win1_r [3];
  sem_pkg::pix_t              win2_r [3];
  sem_pkg::pix_t              win1_nxt [3];
  sem_pkg::pix_t              win2_nxt [3];

  logic [sem_pkg::WID_W-1:0]  w_eff;
  logic [sem_pkg::HGT_W-1:0]  h_eff;
  logic [sem_pkg::COL_W-1:0]  c_use;
  logic                       accept;
  logic                       in_frame;
  logic                       drop;
  logic                       top_ok;
  logic                       mid_ok;
  logic                       emit;
  logic                       last;
  logic                       wrap;
  logic [2*sem_pkg::PIX_W-1:0] ram_rdata;
  logic                       ram_we;
  sem_pkg::pix_t              new_col [3];
  sem_pkg::pix_t              col2 [3];
  sem_pkg::grad_pair_t        grad [3];

  // Width and height in use, clamped to the supported range.
  always_comb begin
    if (width_r == '0) begin
      w_eff = sem_pkg::WID_W'(1);
    end else if (width_r > sem_pkg::WID_W'(sem_pkg::MAX_WIDTH)) begin
      w_eff = sem_pkg::WID_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = sem_pkg::HGT_W'(1);
    end else if (height_r > sem_pkg::HGT_W'(sem_pkg::MAX_HEIGHT)) begin
      h_eff = sem_pkg::HGT_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Input classification: a flush while pixels are due is taken and dropped.
  assign in_stall = (state_r != ST_IDLE) || q_status.full;
  assign accept   = in_valid && !in_stall;
  assign in_frame = row_r < h_eff;
  assign drop     = in_frame && (in_operation == sem_pkg::OP_FLUSH);
  assign c_use    = ({1'b0, col_r} >= w_eff) ? '0 : col_r;

  // Line buffer: each entry holds the upper and middle line pixels of a column.
  assign ram_we = (state_r == ST_WORK);

  sem_ram #(
    .WIDTH (2 * sem_pkg::PIX_W),
    .DEPTH (sem_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata ({ram_rdata[sem_pkg::PIX_W-1:0], pix_r}),
    .raddr (c_use),
    .rdata (ram_rdata)
  );

  // Rows outside the current frame read as zero.
  assign top_ok = (row_r >= sem_pkg::ROW_W'(2)) &&
                  ({1'b0, row_r} <= ({1'b0, h_eff} + 14'd1));
  assign mid_ok = (row_r >= sem_pkg::ROW_W'(1)) && (row_r <= h_eff);

  always_comb begin
    new_col[0] = top_ok ? ram_rdata[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W] : '0;
    new_col[1] = mid_ok ? ram_rdata[sem_pkg::PIX_W-1:0] : '0;
    new_col[2] = pix_r;
  end

  // Window shift; the first column of a row closes the previous row's last pixel.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      col2[a] = (col_r == '0) ? '0 : new_col[a];
      win1_nxt[a] = win1_r[a];
      win2_nxt[a] = win2_r[a];
      if (state_r == ST_WORK) begin
        win1_nxt[a] = (col_r == '0) ? '0 : win2_r[a];
        win2_nxt[a] = new_col[a];
      end
    end
  end

  // Gradient sums per color channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      grad[ch] = sem_pkg::sobel_grad(
        win1_r[0][8*ch +: 8], win2_r[0][8*ch +: 8], col2[0][8*ch +: 8],
        win1_r[1][8*ch +: 8],                       col2[1][8*ch +: 8],
        win1_r[2][8*ch +: 8], win2_r[2][8*ch +: 8], col2[2][8*ch +: 8]);
    end
  end

  assign emit = (row_r >= sem_pkg::ROW_W'(2)) ||
                ((row_r == sem_pkg::ROW_W'(1)) && (col_r != '0));
  assign last = ({1'b0, row_r} == ({1'b0, h_eff} + 14'd1)) && (col_r == '0);
  assign wrap = (({1'b0, col_r} + 12'd1) >= w_eff);

  assign push            = (state_r == ST_WORK) && emit;
  assign push_item.red   = grad[0];
  assign push_item.green = grad[1];
  assign push_item.blue  = grad[2];
  assign push_item.last  = last;

  // Sequencing, raster counters and configuration registers.
  always_comb begin
    state_nxt  = state_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    pix_nxt    = pix_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !drop) begin
          state_nxt = ST_WORK;
          col_nxt   = c_use;
          pix_nxt   = in_frame ? {in_blue_in, in_green_in, in_red_in} : '0;
        end
      end
      ST_WORK: begin
        state_nxt = ST_IDLE;
        if (last) begin
          row_nxt = '0;
          col_nxt = '0;
        end else if (wrap) begin
          row_nxt = row_r + sem_pkg::ROW_W'(1);
          col_nxt = '0;
        end else begin
          col_nxt = col_r + sem_pkg::COL_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      if (cfg_index == sem_pkg::REG_WIDTH) begin
        width_nxt = cfg_data[sem_pkg::WID_W-1:0];
      end else begin
        height_nxt = cfg_data[sem_pkg::HGT_W-1:0];
      end
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      width_r  <= sem_pkg::WID_W'(640);
      height_r <= sem_pkg::HGT_W'(480);
      row_r    <= '0;
      col_r    <= '0;
      for (int a = 0; a < 3; a++) begin
        win1_r[a] <= '0;
        win2_r[a] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      for (int a = 0; a < 3; a++) begin
        win1_r[a] <= win1_nxt[a];
        win2_r[a] <= win2_nxt[a];
      end
    end
    pix_r <= pix_nxt;
  end

  // A result is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("front pushed into a full queue");

  // The work cycle always follows the accept of a non-dropped beat.
  a_work_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !drop) |=> (state_r == ST_WORK))
    else $error("accepted beat did not enter the work cycle");

  // The column in work lies inside the row in use.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORK) |-> ({1'b0, col_r} < w_eff))
    else $error("column out of the row in use");

endmodule

>>> sv/sem_queue.sv
// Small register queue carrying gradient sums from the front to the back end.
// Depends on sem_pkg.
module sem_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sem_pkg::work_t     push_item,
  input  logic               pop,
  output sem_pkg::work_t     pop_item,
  output sem_pkg::q_status_t status
);

  sem_pkg::work_t              mem_r [sem_pkg::QUEUE_DEPTH];
  logic [sem_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sem_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sem_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign status.full  = (count_r == sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + sem_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + sem_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + sem_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - sem_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/sem_back.sv
// Back end of the Sobel block: squares the gradients, takes a bit-serial
// rounded square root per channel and holds the output beat. Depends on sem_pkg.
module sem_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sem_pkg::q_status_t q_status,
  input  sem_pkg::work_t     pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red_edge,
  output logic [7:0]         out_green_edge,
  output logic [7:0]         out_blue_edge,
  output logic               out_frame_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  sem_pkg::work_t              item_r;
  logic [sem_pkg::SUM_W-1:0]   sum_r [3];
  logic [7:0]                  root_r [3];
  logic [2:0]                  step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  red_r, green_r, blue_r;
  logic                        last_r;

  sem_pkg::grad_pair_t         pair [3];
  logic [sem_pkg::SUM_W-1:0]   sum_nxt [3];
  logic [7:0]                  root_nxt [3];
  logic [7:0]                  bit_mask;
  logic                        load_out;

  assign pair[0] = item_r.red;
  assign pair[1] = item_r.green;
  assign pair[2] = item_r.blue;
  assign bit_mask = 8'h80 >> step_r;

  assign pop      = (state_r == ST_IDLE) && !q_status.empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Squared magnitude per channel, and one root bit per cycle:
  // root >= t exactly when sum >= t*t - t + 1.
  always_comb begin
    logic [sem_pkg::ABS_W-1:0] ax;
    logic [sem_pkg::ABS_W-1:0] ay;
    logic [7:0]                trial;
    logic [16:0]               bound;
    for (int ch = 0; ch < 3; ch++) begin
      ax = pair[ch].gx[sem_pkg::GRAD_W-1] ? sem_pkg::ABS_W'(-pair[ch].gx)
                                          : sem_pkg::ABS_W'(pair[ch].gx);
      ay = pair[ch].gy[sem_pkg::GRAD_W-1] ? sem_pkg::ABS_W'(-pair[ch].gy)
                                          : sem_pkg::ABS_W'(pair[ch].gy);
      sum_nxt[ch] = {1'b0, sem_pkg::SQ_W'(ax) * sem_pkg::SQ_W'(ax)}
                    + {1'b0, sem_pkg::SQ_W'(ay) * sem_pkg::SQ_W'(ay)};
      trial = root_r[ch] | bit_mask;
      bound = {1'b0, 16'(trial) * 16'(trial - 8'd1)} + 17'd1;
      root_nxt[ch] = (sem_pkg::SUM_W'(bound) <= sum_r[ch]) ? trial : root_r[ch];
    end
  end

  // Sequencing of one item through square, root and output.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        state_nxt = ST_ITER;
        step_nxt  = '0;
      end
      ST_ITER: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (pop) begin
      item_r <= pop_item;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (state_r == ST_SQ) begin
        sum_r[ch]  <= sum_nxt[ch];
        root_r[ch] <= '0;
      end else if (state_r == ST_ITER) begin
        root_r[ch] <= root_nxt[ch];
      end
    end
    if (load_out) begin
      red_r   <= root_r[0];
      green_r <= root_r[1];
      blue_r  <= root_r[2];
      last_r  <= item_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_edge   = red_r;
  assign out_green_edge = green_r;
  assign out_blue_edge  = blue_r;
  assign out_frame_last = last_r;

  // The output register is only reloaded when it is free or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load_out)
    else $error("output beat overwritten while stalled");

  // The root runs exactly eight steps before the output stage.
  a_iter_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && step_r == 3'd7) |=> (state_r == ST_DONE))
    else $error("root iteration did not end after eight steps");

  // Nothing is taken from the queue while an item is in work.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE && !q_status.empty))
    else $error("queue popped outside idle or when empty");

endmodule

>>> sv/sobel_edge_magnitude_rgb.sv
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
// Pixels enter in raster order for a frame of image_width x image_height; each
// result is the rounded gradient magnitude per color channel, clamped to 255,
// with neighbors outside the image taken as zero. Results lag the input by
// width+1 raster positions, so after the last pixel the source sends width+1
// flush beats and the final result carries out_frame_last. A flush beat sent
// while pixels are still due is taken and dropped. The front end cannot take a
// new beat before it is through with the last, since the registered read of
// its line buffer must return before the window shift and the write-back; the
// back end works one result at a time through load, square, eight square-root
// steps and output load, with the bit-serial square root shared by the three
// channels, and a four-beat queue between them lets the front run ahead. The
// line buffer needs no clearing after reset. Write the size registers only
// while the block is idle; a write restarts the frame.
module sobel_edge_magnitude_rgb (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [7:0]                in_red_in,
  input  logic [7:0]                in_green_in,
  input  logic [7:0]                in_blue_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_red_edge,
  output logic [7:0]                out_green_edge,
  output logic [7:0]                out_blue_edge,
  output logic                      out_frame_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sem_pkg::CFG_W-1:0] cfg_data
);

  sem_pkg::q_status_t q_status;
  sem_pkg::work_t     push_item;
  sem_pkg::work_t     pop_item;
  logic               push;
  logic               pop;

  // Front end: classification, line buffer, window and gradients.
  sem_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  // Queue between the two halves.
  sem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Back end: magnitude and output beat.
  sem_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_edge   (out_red_edge),
    .out_green_edge (out_green_edge),
    .out_blue_edge  (out_blue_edge),
    .out_frame_last (out_frame_last)
  );

endmodule

>>> sim/tb_sobel_edge_magnitude_rgb.sv
// Self-checking testbench for the RGB Sobel edge magnitude block.
// Depends on sem_pkg and sobel_edge_magnitude_rgb with the modules that it instantiates.
module tb_sobel_edge_magnitude_rgb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_operation = sem_pkg::OP_PIXEL;
  logic [7:0]                in_red_in = '0;
  logic [7:0]                in_green_in = '0;
  logic [7:0]                in_blue_in = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                out_red_edge;
  logic [7:0]                out_green_edge;
  logic [7:0]                out_blue_edge;
  logic                      out_frame_last;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = sem_pkg::REG_WIDTH;
  logic [sem_pkg::CFG_W-1:0] cfg_data = '0;

  sobel_edge_magnitude_rgb u_top (.*);

  always #5 clk = ~clk;

  // One edge result per channel plus the frame end marker.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_res_t;

  edge_res_t edge_due[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        beats_sent = 0;
  int        frames_done = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;

  // Predictor state: line buffers, 3x3 window, raster position, registers.
  logic [sem_pkg::PIX_W-1:0] line_upper [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] line_middle[sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] win[3][3];
  int                        row_pos, col_pos, reg_width, reg_height;

  function automatic logic [7:0] chan_mag(input logic [sem_pkg::PIX_W-1:0] p[3][3],
                                          input int sh);
    int v[3][3];
    int gx, gy, s, n, t;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        v[a][b] = (p[a][b] >> sh) & 8'hFF;
    gx = -v[0][0] + v[0][2] - 2*v[1][0] + 2*v[1][2] - v[2][0] + v[2][2];
    gy = -v[0][0] - 2*v[0][1] - v[0][2] + v[2][0] + 2*v[2][1] + v[2][2];
    s = gx*gx + gy*gy;
    n = 0;
    for (int bit_v = 128; bit_v != 0; bit_v >>= 1) begin
      t = n + bit_v;
      if (t*t - t + 1 <= s) n = t;
    end
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  // Advances the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit sobel_predict(input logic op, input logic [7:0] r, g, b,
                                       output edge_res_t res);
    int w, h, rr, c;
    logic [sem_pkg::PIX_W-1:0] pix, top, mid, bot;
    logic [sem_pkg::PIX_W-1:0] calc[3][3];
    bit emit, last;
    w = reg_width; h = reg_height; rr = row_pos; c = col_pos; pix = '0;
    if (w < 1) w = 1;
    if (w > sem_pkg::MAX_WIDTH) w = sem_pkg::MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > sem_pkg::MAX_HEIGHT) h = sem_pkg::MAX_HEIGHT;
    if (c >= w) c = 0;
    res = '0;
    if (rr < h) begin
      if (op == sem_pkg::OP_FLUSH) return 1'b0;
      pix = {b, g, r};
    end
    top = (rr >= 2 && rr - 2 < h) ? line_upper[c] : '0;
    mid = (rr >= 1 && rr - 1 < h) ? line_middle[c] : '0;
    bot = (rr < h) ? pix : '0;
    line_upper[c] = line_middle[c];
    line_middle[c] = pix;
    if (c == 0) begin
      for (int a = 0; a < 3; a++) begin
        calc[a][0] = win[a][1];
        calc[a][1] = win[a][2];
        calc[a][2] = '0;
        win[a][0] = '0;
        win[a][1] = '0;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        win[a][0] = win[a][1];
        win[a][1] = win[a][2];
      end
    end
    win[0][2] = top; win[1][2] = mid; win[2][2] = bot;
    if (c != 0) calc = win;
    emit = (rr >= 2) || (rr == 1 && c >= 1);
    last = (rr == h + 1 && c == 0);
    if (last) begin
      row_pos = 0; col_pos = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0; rr++;
      end
      row_pos = rr; col_pos = c;
    end
    if (!emit) return 1'b0;
    res.red = chan_mag(calc, 0);
    res.green = chan_mag(calc, 8);
    res.blue = chan_mag(calc, 16);
    res.last = last;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drives one beat and waits until it is taken; the predictor runs on acceptance.
  task automatic send_beat(input logic op, input logic [7:0] r, g, b,
                           input bit typed, input edge_res_t typed_res);
    int gap;
    edge_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_red_in <= r; in_green_in <= g; in_blue_in <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (sobel_predict(op, r, g, b, res)) edge_due.push_back(typed ? typed_res : res);
  endtask

  // Lowers valid, waits for every due result, then lets the pipeline settle.
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (edge_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [sem_pkg::CFG_W-1:0] val);
    drain_idle();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sem_pkg::REG_WIDTH) reg_width = val & 12'hFFF;
    else reg_height = val;
    row_pos = 0; col_pos = 0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of random pixels with noise; cut short when broken is set.
  task automatic run_frame(input bit broken);
    int w, h, n, stop_at;
    edge_res_t none;
    none = '0;
    w = (reg_width < 1) ? 1 : (reg_width > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH
                                                                : reg_width;
    h = (reg_height < 1) ? 1 : (reg_height > sem_pkg::MAX_HEIGHT) ? sem_pkg::MAX_HEIGHT
                                                                   : reg_height;
    n = w * h;
    stop_at = broken ? $urandom_range(0, n + w) : n + w + 1;
    quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n + w + 1 && i < stop_at; i++) begin
      if (i < n) begin
        // A flush beat while pixels are due must be dropped.
        if ($urandom_range(0, 15) == 0)
          send_beat(sem_pkg::OP_FLUSH, rand_chan(), rand_chan(), rand_chan(), 1'b0, none);
        send_beat(sem_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan(), 1'b0, none);
      end else begin
        // During the drain a pixel beat counts as a flush.
        send_beat(($urandom_range(0, 3) == 0) ? sem_pkg::OP_PIXEL : sem_pkg::OP_FLUSH,
                  rand_chan(), rand_chan(), rand_chan(), 1'b0, none);
      end
    end
    if (broken) begin
      write_reg(sem_pkg::REG_WIDTH, sem_pkg::CFG_W'(reg_width));
    end else begin
      frames_done++;
    end
  endtask

  // Directed stimulus table: register writes and beats.
  typedef struct {
    bit                        is_cfg;
    logic                      idx;
    logic [sem_pkg::CFG_W-1:0] val;
    logic                      op;
    logic [7:0]                r, g, b;
    bit                        typed;
    edge_res_t                 want;
  } dir_row_t;

  dir_row_t dir_tab[$] = '{
    '{1, sem_pkg::REG_WIDTH,  13'd1, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{1, sem_pkg::REG_HEIGHT, 13'd1, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd255, 8'd0,   8'd128, 0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd0,   8'd0,   8'd0,   0, '0},
    // A single-pixel frame has no neighbors, so its only result is zero and last.
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd0,   8'd0,   8'd0,   1,
      '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{1, sem_pkg::REG_WIDTH,  13'd3, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{1, sem_pkg::REG_HEIGHT, 13'd2, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255, 0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd9,   8'd9,   8'd9,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd255, 8'd0,   8'd255, 0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd0,   8'd255, 8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255, 0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255, 0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd0,   8'd0,   8'd0,   0, '0},
    '{0, sem_pkg::REG_WIDTH,  13'd0, sem_pkg::OP_FLUSH, 8'd0,   8'd0,   8'd0,   0, '0}
  };

  // Receiver stall: random bursts, mostly short, a few long.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) < 3) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 30) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin
    edge_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (edge_due.size() == 0) begin
        report_mismatch("unexpected result, red", out_red_edge, -1);
      end else begin
        want = edge_due.pop_front();
        if (out_red_edge !== want.red) report_mismatch("red_edge", out_red_edge, want.red);
        if (out_green_edge !== want.green)
          report_mismatch("green_edge", out_green_edge, want.green);
        if (out_blue_edge !== want.blue)
          report_mismatch("blue_edge", out_blue_edge, want.blue);
        if (out_frame_last !== want.last)
          report_mismatch("frame_last", out_frame_last, want.last);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, edge_due.size());
      $display("FAIL");
      $finish;
    end
  end

  int ext_w[6] = '{0, 1, 2, 40, 1, 5};
  int ext_h[6] = '{3, 0, 1, 2, 8, 0};

  initial begin
    reg_width = 640; reg_height = 480; row_pos = 0; col_pos = 0;
    for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
      line_upper[i] = '0; line_middle[i] = '0;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        win[a][b] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_beat(dir_tab[i].op, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b,
                     dir_tab[i].typed, dir_tab[i].want);
    end

    // Narrow and short sizes, including zero sizes that clamp to one, one frame each.
    foreach (ext_w[i]) begin
      write_reg(sem_pkg::REG_WIDTH, sem_pkg::CFG_W'(ext_w[i]));
      write_reg(sem_pkg::REG_HEIGHT, sem_pkg::CFG_W'(ext_h[i]));
      run_frame(1'b0);
    end

    // Random small sizes with random frames, some of them cut short.
    while (beats_sent < 1500) begin
      write_reg(sem_pkg::REG_WIDTH, sem_pkg::CFG_W'($urandom_range(0, 12)));
      write_reg(sem_pkg::REG_HEIGHT, sem_pkg::CFG_W'($urandom_range(0, 8)));
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 9) == 0);
    end

    quiet = 1'b0;
    drain_idle();
    $display("covered %0d beats, %0d results, %0d complete frames over many sizes",
             beats_sent, results_seen, frames_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
